// File: src/ketrq_pkg.sv
// Shared types and constants for the key edge, toggle and repeat qualifier.
`timescale 1ns / 1ps
`default_nettype none

package ketrq_pkg;

  // Field widths fixed by the query format
  localparam int OP_W      = 3;
  localparam int KEY_IDX_W = 8;
  localparam int TIME_W    = 32;

  // Default number of keys tracked
  localparam int KEY_COUNT_DEFAULT = 256;

  // Query codes
  localparam logic [OP_W-1:0] OP_LEVEL   = 3'd0;
  localparam logic [OP_W-1:0] OP_REPEAT  = 3'd1;
  localparam logic [OP_W-1:0] OP_PRESS   = 3'd2;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd3;
  localparam logic [OP_W-1:0] OP_TOGGLE  = 3'd4;

  // Per-key record kept in the key RAM
  typedef struct packed {
    logic              press_seen;
    logic              held_seen;
    logic              toggle_state;
    logic [TIME_W-1:0] last_fire_time;
  } key_entry_t;

  // Outcome of one query: the answer bit and the record to write back
  typedef struct packed {
    logic       answer;
    logic       wr_en;
    key_entry_t entry;
  } query_out_t;

endpackage

`default_nettype wire

// File: src/ketrq_key_ram.sv
// Per-key record RAM with registered read and a clearing sweep after reset.
`timescale 1ns / 1ps
`default_nettype none

module ketrq_key_ram #(
  parameter int KEY_COUNT = ketrq_pkg::KEY_COUNT_DEFAULT,
  parameter int ADDR_W    = $clog2(KEY_COUNT)
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      rd_en,
  input  wire  [ADDR_W-1:0]        rd_addr,
  output ketrq_pkg::key_entry_t    rd_data,
  input  wire                      wr_en,
  input  wire  [ADDR_W-1:0]        wr_addr,
  input  ketrq_pkg::key_entry_t    wr_data,
  output logic                     clearing
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(KEY_COUNT - 1);

  ketrq_pkg::key_entry_t mem [KEY_COUNT];

  logic [ADDR_W-1:0] clr_addr;
  logic              clr_active;

  // Sweep every entry to zero once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == LAST_ADDR) begin
        clr_active <= 1'b0;
      end
    end
  end

  // Single write port shared by the sweep and query write-back; registered read
  always_ff @(posedge clk) begin
    if (clr_active) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign clearing = clr_active;

endmodule

`default_nettype wire

// File: src/ketrq_query_logic.sv
// Combinational evaluation of one key query against that key's record.
`timescale 1ns / 1ps
`default_nettype none

module ketrq_query_logic (
  input  wire  [ketrq_pkg::OP_W-1:0]   operation,
  input  wire                          in_range,
  input  wire                          level,
  input  wire  [ketrq_pkg::TIME_W-1:0] now_time,
  input  wire  [ketrq_pkg::TIME_W-1:0] repeat_delay,
  input  ketrq_pkg::key_entry_t        entry,
  output ketrq_pkg::query_out_t        result
);

  logic [ketrq_pkg::TIME_W-1:0] elapsed;
  logic                         press_edge;

  // Wrapping elapsed time since the last repeat fire
  assign elapsed    = now_time - entry.last_fire_time;
  assign press_edge = level & ~entry.press_seen;

  always_comb begin
    result.answer = 1'b0;
    result.wr_en  = in_range;
    result.entry  = entry;
    unique case (operation)
      ketrq_pkg::OP_LEVEL: begin
        result.answer = level;
      end
      ketrq_pkg::OP_REPEAT: begin
        if (level && (elapsed > repeat_delay)) begin
          result.entry.last_fire_time = now_time;
          result.answer               = 1'b1;
        end
      end
      ketrq_pkg::OP_PRESS: begin
        result.entry.press_seen = level;
        result.answer           = press_edge;
      end
      ketrq_pkg::OP_RELEASE: begin
        if (level) begin
          result.entry.held_seen = 1'b1;
        end else if (entry.held_seen) begin
          result.entry.held_seen = 1'b0;
          result.answer          = 1'b1;
        end
      end
      ketrq_pkg::OP_TOGGLE: begin
        result.entry.press_seen   = level;
        result.entry.toggle_state = entry.toggle_state ^ press_edge;
        result.answer             = entry.toggle_state ^ press_edge;
      end
      default: begin
        result.wr_en = 1'b0;
      end
    endcase
    // Drop queries for keys beyond the tracked range
    if (!in_range) begin
      result.answer = 1'b0;
      result.wr_en  = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: src/key_edge_toggle_repeat_qualifier_unit.sv
// Top level of the key edge, toggle and auto-repeat qualifier.
`timescale 1ns / 1ps
`default_nettype none

// Answers one key query per transaction: level, auto-repeat, press edge, release
// edge or toggle, each against a per-key record held in an internal RAM. A query
// is taken on any clock edge with start high and busy low, one per cycle, and its
// answer appears on answer with done high for exactly one cycle, after the
// registered RAM read and then the evaluation and write-back stage. The receiver
// cannot stall, so done must be captured when it shows. Back-to-back queries on
// the same key are forwarded from the previous write-back. After reset, busy
// stays high while the RAM is swept to zero; focus_enable may be written through
// cfg_valid at any time and reads as 1 after reset, and should change only when
// no query is in flight.
module key_edge_toggle_repeat_qualifier_unit #(
  parameter int KEY_COUNT = ketrq_pkg::KEY_COUNT_DEFAULT
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  output logic                             busy,
  input  wire  [ketrq_pkg::OP_W-1:0]       operation,
  input  wire  [ketrq_pkg::KEY_IDX_W-1:0]  key_index,
  input  wire                              key_pressed,
  input  wire  [ketrq_pkg::TIME_W-1:0]     now_time,
  input  wire  [ketrq_pkg::TIME_W-1:0]     repeat_delay,
  output logic                             done,
  output logic                             answer,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire                              cfg_data
);

  localparam int ADDR_W = $clog2(KEY_COUNT);

  logic                  accept;
  logic                  in_range;
  logic [ADDR_W-1:0]     in_addr;
  logic                  clearing;
  logic                  focus_enable;

  // Evaluation stage registers
  logic                               s1_valid;
  logic [ketrq_pkg::OP_W-1:0]         s1_op;
  logic [ADDR_W-1:0]                  s1_addr;
  logic                               s1_in_range;
  logic                               s1_pressed;
  logic [ketrq_pkg::TIME_W-1:0]       s1_now;
  logic [ketrq_pkg::TIME_W-1:0]       s1_delay;

  // Last write-back, for a read that raced it
  logic                  fwd_valid;
  logic [ADDR_W-1:0]     fwd_addr;
  ketrq_pkg::key_entry_t fwd_data;

  ketrq_pkg::key_entry_t rd_data;
  ketrq_pkg::key_entry_t entry_cur;
  ketrq_pkg::query_out_t qry;
  logic                  level;
  logic                  wr_en;

  assign busy      = clearing;
  assign accept    = start && !busy;
  assign in_range  = (32'(key_index) < 32'(KEY_COUNT));
  assign in_addr   = ADDR_W'(key_index);
  assign cfg_ready = 1'b1;

  // Hold the focus register
  always_ff @(posedge clk) begin
    if (rst) begin
      focus_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      focus_enable <= cfg_data;
    end
  end

  ketrq_key_ram #(
    .KEY_COUNT (KEY_COUNT),
    .ADDR_W    (ADDR_W)
  ) u_ram (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept && in_range),
    .rd_addr  (in_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (s1_addr),
    .wr_data  (qry.entry),
    .clearing (clearing)
  );

  // Capture the accepted query
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_op       <= operation;
      s1_addr     <= in_addr;
      s1_in_range <= in_range;
      s1_pressed  <= key_pressed;
      s1_now      <= now_time;
      s1_delay    <= repeat_delay;
    end
  end

  // Take the record from the previous write-back when it hit the same key
  assign entry_cur = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_data : rd_data;
  assign level     = s1_pressed & focus_enable;

  ketrq_query_logic u_logic (
    .operation    (s1_op),
    .in_range     (s1_in_range),
    .level        (level),
    .now_time     (s1_now),
    .repeat_delay (s1_delay),
    .entry        (entry_cur),
    .result       (qry)
  );

  assign wr_en = s1_valid && qry.wr_en;

  // Track the write-back and register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      fwd_valid <= wr_en;
      done      <= s1_valid;
    end
    fwd_addr <= s1_addr;
    fwd_data <= qry.entry;
    answer   <= qry.answer;
  end

endmodule

`default_nettype wire

// File: src/ketrq_checker.sv
// Port-level checks for the key qualifier and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ketrq_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        start,
  input wire                        busy,
  input wire [ketrq_pkg::OP_W-1:0]  operation,
  input wire                        key_pressed,
  input wire                        done,
  input wire                        answer
);

  // Every accepted transaction yields a result after the RAM read and evaluation stages
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted transaction produced no result");

  // No result without a matching accepted transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a matching transaction");

  // A level query on a released key answers zero
  a_level_released: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == ketrq_pkg::OP_LEVEL) && !key_pressed)
      |=> ##1 !answer)
    else $error("level query on released key answered one");

  // Leaving reset starts the clearing sweep
  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> busy)
    else $error("busy low right after reset");

  // No result appears while the sweep runs
  a_quiet_when_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result during clearing sweep");

endmodule

bind key_edge_toggle_repeat_qualifier_unit ketrq_checker u_ketrq_checker (.*);

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for the key edge, toggle and auto-repeat qualifier.
`timescale 1ns / 1ps

module tb_top;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 10;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 160;
  localparam int HOT_KEYS     = 8;
  localparam int SETTLE       = 4;
  localparam int CYCLE_LIMIT  = 200000;

  localparam int OP_W      = ketrq_pkg::OP_W;
  localparam int KEY_IDX_W = ketrq_pkg::KEY_IDX_W;
  localparam int TIME_W    = ketrq_pkg::TIME_W;
  localparam int KEYS      = ketrq_pkg::KEY_COUNT_DEFAULT;

  // Codes the block leaves unused
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                 focus;
    logic [OP_W-1:0]      op;
    logic [KEY_IDX_W-1:0] key;
    logic                 pressed;
    logic [TIME_W-1:0]    now;
    logic [TIME_W-1:0]    delay;
    logic                 typed;
    logic                 answer;
  } query_row_t;

  typedef struct packed {
    logic                 answer;
    logic [OP_W-1:0]      op;
    logic [KEY_IDX_W-1:0] key;
  } answer_check_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [OP_W-1:0]      operation = '0;
  logic [KEY_IDX_W-1:0] key_index = '0;
  logic                 key_pressed = 1'b0;
  logic [TIME_W-1:0]    now_time = '0;
  logic [TIME_W-1:0]    repeat_delay = '0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_data = 1'b0;
  logic                 busy;
  logic                 done;
  logic                 answer;
  logic                 cfg_ready;

  // Shadow copy of the per-key records and the focus register
  logic              focus_model;
  logic              key_press_seen [KEYS];
  logic              key_held_seen  [KEYS];
  logic              key_toggle     [KEYS];
  logic [TIME_W-1:0] key_fire_time  [KEYS];

  answer_check_t pending_answers [$];
  answer_check_t arrived_check;
  query_row_t    directed_rows [$];

  int error_count   = 0;
  int checked_count = 0;
  int query_count   = 0;
  int focus_writes  = 0;
  int cycle_count   = 0;
  int op_counts [8];

  key_edge_toggle_repeat_qualifier_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .key_index    (key_index),
    .key_pressed  (key_pressed),
    .now_time     (now_time),
    .repeat_delay (repeat_delay),
    .done         (done),
    .answer       (answer),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d answers outstanding", $time, pending_answers.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Compare each answer with the oldest outstanding query
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: answer %0b with no query outstanding", $time, answer);
        error_count++;
      end else begin
        arrived_check = pending_answers.pop_front();
        checked_count++;
        if (answer !== arrived_check.answer) begin
          $display("%0t: answer mismatch op %0d key %0d expected %0b actual %0b", $time,
                   arrived_check.op, arrived_check.key, arrived_check.answer, answer);
          error_count++;
        end
      end
    end
  end

  // Press-edge detection shared by the press and toggle queries
  function automatic logic step_press_edge(input logic [KEY_IDX_W-1:0] key,
                                           input logic level);
    if (!level) begin
      key_press_seen[key] = 1'b0;
      return 1'b0;
    end
    if (key_press_seen[key]) return 1'b0;
    key_press_seen[key] = 1'b1;
    return 1'b1;
  endfunction

  // Evaluate one query against the shadow records and update them
  function automatic logic qualify_key(input logic [OP_W-1:0] op,
                                       input logic [KEY_IDX_W-1:0] key,
                                       input logic pressed,
                                       input logic [TIME_W-1:0] now,
                                       input logic [TIME_W-1:0] delay);
    logic              level;
    logic              result;
    logic [TIME_W-1:0] elapsed;
    level   = pressed & focus_model;
    result  = 1'b0;
    elapsed = now - key_fire_time[key];
    case (op)
      ketrq_pkg::OP_LEVEL: result = level;
      ketrq_pkg::OP_REPEAT: begin
        if (level && elapsed > delay) begin
          key_fire_time[key] = now;
          result = 1'b1;
        end
      end
      ketrq_pkg::OP_PRESS: result = step_press_edge(key, level);
      ketrq_pkg::OP_RELEASE: begin
        if (level) begin
          key_held_seen[key] = 1'b1;
        end else if (key_held_seen[key]) begin
          key_held_seen[key] = 1'b0;
          result = 1'b1;
        end
      end
      ketrq_pkg::OP_TOGGLE: begin
        if (step_press_edge(key, level)) key_toggle[key] = ~key_toggle[key];
        result = key_toggle[key];
      end
      default: result = 1'b0;
    endcase
    return result;
  endfunction

  // Drive one query, hold it until accepted, then record the expected answer
  task automatic send_query(input logic [OP_W-1:0] op, input logic [KEY_IDX_W-1:0] key,
                            input logic pressed, input logic [TIME_W-1:0] now,
                            input logic [TIME_W-1:0] delay, input logic typed,
                            input logic typed_answer);
    logic          predicted;
    answer_check_t entry;
    operation    <= op;
    key_index    <= key;
    key_pressed  <= pressed;
    now_time     <= now;
    repeat_delay <= delay;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
    predicted    = qualify_key(op, key, pressed, now, delay);
    entry.answer = typed ? typed_answer : predicted;
    entry.op     = op;
    entry.key    = key;
    pending_answers.push_back(entry);
    query_count++;
    op_counts[op]++;
  endtask

  // Drop start and wait until every outstanding answer has arrived
  task automatic drain_answers();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Write focus_enable once the block is idle
  task automatic write_focus(input logic value);
    drain_answers();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    focus_model  = value;
    focus_writes++;
  endtask

  task automatic add_row(input logic focus, input logic [OP_W-1:0] op,
                         input logic [KEY_IDX_W-1:0] key, input logic pressed,
                         input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] delay,
                         input logic typed, input logic typed_answer);
    query_row_t row;
    row = '{focus, op, key, pressed, now, delay, typed, typed_answer};
    directed_rows.push_back(row);
  endtask

  initial begin
    logic [KEY_IDX_W-1:0] hot_keys [HOT_KEYS];
    logic                 key_level [KEYS];
    logic [TIME_W-1:0]    sim_ms;
    logic [TIME_W-1:0]    now_pick;
    logic [TIME_W-1:0]    delay_pick;
    logic [OP_W-1:0]      op_pick;
    logic [KEY_IDX_W-1:0] key_pick;
    logic                 pressed_pick;
    logic                 phase_focus;
    int                   issued;
    int                   burst;
    int                   gap;
    int                   pause_at;

    // Clear the shadow state as reset does
    focus_model = 1'b1;
    for (int k = 0; k < KEYS; k++) begin
      key_press_seen[k] = 1'b0;
      key_held_seen[k]  = 1'b0;
      key_toggle[k]     = 1'b0;
      key_fire_time[k]  = '0;
      key_level[k]      = 1'b0;
    end
    for (int i = 0; i < 8; i++) op_counts[i] = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed table: level, repeat with wrap and delay extremes, edges, toggle,
    // spare codes and focus masking; back-to-back rows exercise forwarding
    add_row(1'b1, ketrq_pkg::OP_LEVEL,   8'd0,   1'b1, 32'd0, 32'd0, 1'b1, 1'b1);
    add_row(1'b1, ketrq_pkg::OP_LEVEL,   8'd255, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            1'b1, 1'b0);
    add_row(1'b1, ketrq_pkg::OP_REPEAT,  8'd5,   1'b1, 32'd0, 32'd0, 1'b1, 1'b0);
    add_row(1'b1, ketrq_pkg::OP_REPEAT,  8'd5,   1'b1, 32'd1, 32'd0, 1'b1, 1'b1);
    add_row(1'b1, ketrq_pkg::OP_REPEAT,  8'd5,   1'b1, 32'd0, 32'hFFFF_FFFE, 1'b1, 1'b1);
    add_row(1'b1, ketrq_pkg::OP_REPEAT,  8'd5,   1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            1'b1, 1'b0);
    add_row(1'b1, ketrq_pkg::OP_REPEAT,  8'd5,   1'b0, 32'd100, 32'd0, 1'b1, 1'b0);
    add_row(1'b1, ketrq_pkg::OP_PRESS,   8'd255, 1'b1, 32'd0, 32'd0, 1'b1, 1'b1);
    add_row(1'b1, ketrq_pkg::OP_PRESS,   8'd255, 1'b1, 32'd0, 32'd0, 1'b1, 1'b0);
    add_row(1'b1, ketrq_pkg::OP_PRESS,   8'd255, 1'b0, 32'd0, 32'd0, 1'b1, 1'b0);
    add_row(1'b1, ketrq_pkg::OP_PRESS,   8'd255, 1'b1, 32'd0, 32'd0, 1'b1, 1'b1);
    add_row(1'b1, ketrq_pkg::OP_RELEASE, 8'd7,   1'b0, 32'd0, 32'd0, 1'b1, 1'b0);
    add_row(1'b1, ketrq_pkg::OP_RELEASE, 8'd7,   1'b1, 32'd0, 32'd0, 1'b1, 1'b0);
    add_row(1'b1, ketrq_pkg::OP_RELEASE, 8'd7,   1'b0, 32'd0, 32'd0, 1'b1, 1'b1);
    add_row(1'b1, ketrq_pkg::OP_RELEASE, 8'd7,   1'b0, 32'd0, 32'd0, 1'b1, 1'b0);
    add_row(1'b1, ketrq_pkg::OP_TOGGLE,  8'd9,   1'b1, 32'd0, 32'd0, 1'b1, 1'b1);
    add_row(1'b1, ketrq_pkg::OP_TOGGLE,  8'd9,   1'b1, 32'd0, 32'd0, 1'b1, 1'b1);
    add_row(1'b1, ketrq_pkg::OP_TOGGLE,  8'd9,   1'b0, 32'd0, 32'd0, 1'b1, 1'b1);
    add_row(1'b1, ketrq_pkg::OP_TOGGLE,  8'd9,   1'b1, 32'd0, 32'd0, 1'b1, 1'b0);
    add_row(1'b1, OP_SPARE_LO,           8'd9,   1'b1, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0);
    add_row(1'b1, OP_SPARE_HI,           8'd5,   1'b1, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0);
    add_row(1'b0, ketrq_pkg::OP_LEVEL,   8'd0,   1'b1, 32'd0, 32'd0, 1'b1, 1'b0);
    add_row(1'b0, ketrq_pkg::OP_RELEASE, 8'd7,   1'b1, 32'd0, 32'd0, 1'b1, 1'b0);
    add_row(1'b0, ketrq_pkg::OP_PRESS,   8'd255, 1'b1, 32'd0, 32'd0, 1'b1, 1'b0);
    add_row(1'b1, ketrq_pkg::OP_PRESS,   8'd255, 1'b1, 32'd0, 32'd0, 1'b1, 1'b1);
    add_row(1'b1, ketrq_pkg::OP_TOGGLE,  8'd9,   1'b1, 32'd200, 32'd0, 1'b0, 1'b0);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].focus != focus_model) write_focus(directed_rows[r].focus);
      send_query(directed_rows[r].op, directed_rows[r].key, directed_rows[r].pressed,
                 directed_rows[r].now, directed_rows[r].delay, directed_rows[r].typed,
                 directed_rows[r].answer);
    end

    // Random phases: keys mostly from a small hot set, levels that persist
    // between queries, a slowly advancing clock, occasional noise
    sim_ms = 32'd1000;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0)
        phase_focus = 1'b1;
      else if (phase == 1 || phase == 5)
        phase_focus = 1'b0;
      else
        phase_focus = ($urandom_range(0, 3) != 0);
      write_focus(phase_focus);
      if (phase == 3) sim_ms = 32'hFFFF_FF00;
      for (int i = 0; i < HOT_KEYS; i++) hot_keys[i] = KEY_IDX_W'($urandom_range(0, 255));
      pause_at = $urandom_range(20, PHASE_ITEMS - 20);
      issued = 0;
      while (issued < PHASE_ITEMS) begin
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
        for (int b = 0; b < burst && issued < PHASE_ITEMS; b++) begin
          if ($urandom_range(0, 24) == 0)
            op_pick = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
          else
            op_pick = OP_W'($urandom_range(ketrq_pkg::OP_LEVEL, ketrq_pkg::OP_TOGGLE));
          key_pick = ($urandom_range(0, 4) != 0) ? hot_keys[$urandom_range(0, HOT_KEYS - 1)]
                                                 : KEY_IDX_W'($urandom_range(0, 255));
          if ($urandom_range(0, 6) == 0) key_level[key_pick] = ~key_level[key_pick];
          pressed_pick = ($urandom_range(0, 19) == 0) ? 1'($urandom_range(0, 1))
                                                      : key_level[key_pick];
          sim_ms += ($urandom_range(0, 49) == 0) ? $urandom : $urandom_range(0, 20);
          now_pick = ($urandom_range(0, 49) == 0) ? $urandom : sim_ms;
          case ($urandom_range(0, 9))
            0, 1:    delay_pick = '0;
            2:       delay_pick = '1;
            3, 4:    delay_pick = $urandom;
            default: delay_pick = $urandom_range(0, 120);
          endcase
          send_query(op_pick, key_pick, pressed_pick, now_pick, delay_pick, 1'b0, 1'b0);
          issued++;
          // Hold off once per phase until the pipeline is empty
          if (issued == pause_at) drain_answers();
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    drain_answers();
    repeat (8) @(posedge clk);

    $display("tb_top: %0d queries (%0d directed), %0d answers checked, %0d focus writes",
             query_count, directed_rows.size(), checked_count, focus_writes);
    $display("tb_top: mix level %0d repeat %0d press %0d release %0d toggle %0d spare %0d",
             op_counts[ketrq_pkg::OP_LEVEL], op_counts[ketrq_pkg::OP_REPEAT],
             op_counts[ketrq_pkg::OP_PRESS], op_counts[ketrq_pkg::OP_RELEASE],
             op_counts[ketrq_pkg::OP_TOGGLE],
             op_counts[5] + op_counts[6] + op_counts[7]);
    if (error_count == 0 && pending_answers.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
src/ketrq_pkg.sv
src/ketrq_key_ram.sv
src/ketrq_query_logic.sv
src/key_edge_toggle_repeat_qualifier_unit.sv
src/ketrq_checker.sv
sim/tb_top.sv
